>>> rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared widths, character codes and the double-dabble step function for the
// signed integer to decimal ascii formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int BCD_DIGITS      = 10;                // enough for 2^32 - 1
    localparam int MAX_DIGITS      = 10;                // digits kept, low end first
    localparam int STEP_STAGES     = 4;
    localparam int STEPS_PER_STAGE = DATA_W / STEP_STAGES;
    localparam int IDX_W           = $clog2(BCD_DIGITS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        bcd_t              bcd;
        logic [DATA_W-1:0] bin;
    } dd_t;

    // one pipeline stage worth of shift-and-add-3 steps
    function automatic dd_t dd_run(dd_t d);
        dd_t r;
        r = d;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
                if (r.bcd[i] >= 4'd5) begin
                    r.bcd[i] = r.bcd[i] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Formats a 32-bit two's complement integer as decimal ascii text, one
// character per output request.
// ----------------------------------------------------------------------------
// usage
//   s_value/s_valid/s_ready carry one signed 32-bit number per request.
//   m_character/m_last/m_valid/m_ready return its text: '-' first for a
//   negative number, then the digits most significant first, no leading
//   zeros; zero gives a single '0'. m_last marks the final character.
// pipeline and throughput
//   the number goes through a magnitude stage and four double-dabble stages
//   (eight shift steps each), then into a character emitter. the emitter
//   sends one character per cycle while the output is not stalled; a number
//   is 1 to 11 characters (digit count plus one for a minus sign). up to
//   five numbers queue in the pipeline behind it, and a new one is taken in
//   the same cycle the emitter hands out the last character of the previous.
// reset and stalls
//   aresetn (synchronous, active low) empties every stage and the output
//   register. when m_ready is low the output register holds, the emitter
//   stops, stages fill up and s_ready drops once the pipeline is full;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [i2a_pkg::DATA_W-1:0] s_value,
    input  logic                           s_valid,
    output logic                           s_ready,
    output logic [i2a_pkg::CHAR_W-1:0]     m_character,
    output logic                           m_last,
    output logic                           m_valid,
    input  logic                           m_ready
);

    localparam int NS = i2a_pkg::STEP_STAGES;

    // pipeline stage 0 holds sign and magnitude, stages 1..NS the conversion
    logic             vld_reg [0:NS];
    logic             neg_reg [0:NS];
    i2a_pkg::dd_t     dd_reg  [0:NS];
    i2a_pkg::dd_t     dd_next [1:NS];
    logic             rdy     [0:NS];

    // character emitter
    logic                       busy_reg;
    logic                       minus_reg;
    logic [i2a_pkg::IDX_W-1:0]  idx_reg;
    i2a_pkg::bcd_t              em_bcd_reg;

    // output register
    logic                        out_valid_reg;
    logic [i2a_pkg::CHAR_W-1:0]  out_char_reg;
    logic                        out_last_reg;

    logic                        out_free;
    logic                        emit_fire;
    logic                        emit_final;
    logic                        em_ready;
    logic                        em_load;
    logic [i2a_pkg::IDX_W-1:0]   top_idx;
    logic [i2a_pkg::DATA_W-1:0]  in_mag;
    logic [i2a_pkg::CHAR_W-1:0]  char_next;

    // output register frees when empty or when its request is taken
    assign out_free   = !out_valid_reg || m_ready;
    assign emit_fire  = busy_reg && out_free;
    assign emit_final = emit_fire && !minus_reg && (idx_reg == '0);
    // emitter takes the next number while sending the final character
    assign em_ready   = !busy_reg || emit_final;
    assign em_load    = vld_reg[NS] && em_ready;

    // a stage advances when empty or when the one after it advances
    always_comb begin
        rdy[NS] = !vld_reg[NS] || em_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];

    // two's complement magnitude, also right for the most negative value
    assign in_mag = s_value[i2a_pkg::DATA_W-1] ? (~s_value + 1'b1) : s_value;

    // shift-and-add-3 stages
    always_comb begin
        for (int k = 1; k <= NS; k++) begin
            dd_next[k] = i2a_pkg::dd_run(dd_reg[k-1]);
        end
    end

    // index of the most significant digit to send, capped to the kept digits
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
            if (dd_reg[NS].bcd[i] != 4'd0) begin
                top_idx = i2a_pkg::IDX_W'(i);
            end
        end
        if (int'(top_idx) > i2a_pkg::MAX_DIGITS - 1) begin
            top_idx = i2a_pkg::IDX_W'(i2a_pkg::MAX_DIGITS - 1);
        end
    end

    // minus sign first, then digits counting down
    always_comb begin
        if (minus_reg) begin
            char_next = i2a_pkg::CH_MINUS;
        end else begin
            char_next = i2a_pkg::CH_ZERO + {4'd0, em_bcd_reg[idx_reg]};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) begin
                vld_reg[k] <= 1'b0;
            end
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k <= NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (em_load) begin
                busy_reg <= 1'b1;
            end else if (emit_final) begin
                busy_reg <= 1'b0;
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            neg_reg[0]    <= s_value[i2a_pkg::DATA_W-1];
            dd_reg[0].bcd <= '0;
            dd_reg[0].bin <= in_mag;
        end
        for (int k = 1; k <= NS; k++) begin
            if (rdy[k]) begin
                neg_reg[k] <= neg_reg[k-1];
                dd_reg[k]  <= dd_next[k];
            end
        end
        if (em_load) begin
            minus_reg  <= neg_reg[NS];
            idx_reg    <= top_idx;
            em_bcd_reg <= dd_reg[NS].bcd;
        end else if (emit_fire) begin
            if (minus_reg) begin
                minus_reg <= 1'b0;
            end else if (idx_reg != '0) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        if (emit_fire) begin
            out_char_reg <= char_next;
            out_last_reg <= !minus_reg && (idx_reg == '0);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_character = out_char_reg;
    assign m_last      = out_last_reg;

endmodule

>>> rtl/core/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the decimal ascii formatter, bound to the top level.
// ----------------------------------------------------------------------------
module i2a_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic signed [i2a_pkg::DATA_W-1:0] s_value,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [i2a_pkg::CHAR_W-1:0]        m_character,
    input logic                              m_last,
    input logic                              m_valid,
    input logic                              m_ready
);

    // only minus or decimal digits leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == i2a_pkg::CH_MINUS)
                 || ((m_character >= i2a_pkg::CH_ZERO)
                 && (m_character <= i2a_pkg::CH_ZERO + 8'd9)))
        else $error("bad character code");

    // a minus sign is never the end of a number
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_character == i2a_pkg::CH_MINUS)) |-> !m_last)
        else $error("minus sign flagged last");

    // after a minus sign the next character is a nonzero digit
    a_no_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_character == i2a_pkg::CH_MINUS)) |=>
        !(m_valid && ((m_character == i2a_pkg::CH_ZERO)
                   || (m_character == i2a_pkg::CH_MINUS))))
        else $error("leading zero or repeated minus");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("stalled result changed");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_top i2a_checker u_i2a_checker (.*);

>>> tb/sv/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Self-checking bench for the signed integer to decimal ascii formatter: a
// directed table of corner values, then random values of every size and
// sign, with bursty input requests, a stalling output side and a long
// output hold-off. Every character is compared against typed text or a local predictor.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top;

    // ------------------------------------------------------------------------
    // clock, reset and block ports, the driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic signed [i2a_pkg::DATA_W-1:0] s_value     = '0;
    logic                              s_valid     = 1'b0;
    logic                              s_ready;
    logic [i2a_pkg::CHAR_W-1:0]        m_character;
    logic                              m_last;
    logic                              m_valid;
    logic                              m_ready     = 1'b0;

    always #5 aclk = ~aclk;

    signed_int_to_decimal_ascii_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_character (m_character),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    // ------------------------------------------------------------------------
    // expected characters, oldest first
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } text_char_t;

    text_char_t pending_text [$];
    int         mismatch_count = 0;

    // decimal text of one number: sign first, then digits from the top,
    // keeping at most MAX_DIGITS of the low-order digits
    function automatic void predict_decimal_text(input logic [i2a_pkg::DATA_W-1:0] raw);
        logic [i2a_pkg::DATA_W-1:0] mag;
        logic [3:0]                 digit_buf [i2a_pkg::MAX_DIGITS];
        int                         nd;
        nd = 0;
        if (raw == '0) begin
            pending_text.push_back('{ch: i2a_pkg::CH_ZERO, last: 1'b1});
            return;
        end
        if (raw[i2a_pkg::DATA_W-1]) begin
            pending_text.push_back('{ch: i2a_pkg::CH_MINUS, last: 1'b0});
            mag = '0 - raw;                 // unsigned, so the most negative fits
        end else begin
            mag = raw;
        end
        while (mag != '0 && nd < i2a_pkg::MAX_DIGITS) begin
            digit_buf[nd] = 4'(mag % 10);
            mag           = mag / 10;
            nd++;
        end
        while (nd > 0) begin
            nd--;
            pending_text.push_back('{ch: i2a_pkg::CH_ZERO + i2a_pkg::CHAR_W'(digit_buf[nd]),
                                     last: (nd == 0)});
        end
    endfunction

    // ------------------------------------------------------------------------
    // directed table: expected text typed in where it is obvious,
    // empty text means the predictor decides
    // ------------------------------------------------------------------------
    typedef struct {
        logic [i2a_pkg::DATA_W-1:0] value;
        string                      text;
    } dir_row_t;

    localparam int N_DIR = 21;

    dir_row_t dir_rows [N_DIR] = '{
        '{32'h0000_0000, "0"},              // zero gives a single character
        '{32'h0000_0001, "1"},
        '{32'hFFFF_FFFF, "-1"},
        '{32'h0000_0009, "9"},
        '{32'h0000_000A, "10"},
        '{32'hFFFF_FFF6, "-10"},
        '{32'h7FFF_FFFF, "2147483647"},     // largest positive
        '{32'h8000_0000, "-2147483648"},    // most negative, magnitude overflows signed
        '{32'h8000_0001, "-2147483647"},
        '{32'd999999999, "999999999"},
        '{32'd1000000000, "1000000000"},    // first ten-digit value
        '{32'hC465_3601, "-999999999"},
        '{32'h0000_002A, "42"},
        '{32'h0000_0064, ""},
        '{32'hAAAA_AAAA, ""},               // alternating bit patterns
        '{32'h5555_5555, ""},
        '{32'hFFFF_0000, ""},
        '{32'h0000_FFFF, ""},
        '{32'd123456789, ""},
        '{32'hC521_97CF, ""},
        '{32'hFFFF_FC18, ""}
    };

    // ------------------------------------------------------------------------
    // output side: check accepted characters, stall on a pattern of its own
    // and honor long hold-off requests from the sender
    // ------------------------------------------------------------------------
    int unsigned hold_id   = 0;    // bumped by the sender to ask for a hold-off
    int unsigned hold_seen = 0;
    int          hold_left = 0;
    int          rx_mode   = 0;
    int unsigned rx_cycle  = 0;

    always @(posedge aclk) begin
        text_char_t exp_char;
        if (aresetn && m_valid && m_ready) begin
            if (pending_text.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected character %h last %0b", m_character, m_last);
            end else begin
                exp_char = pending_text.pop_front();
                if (m_character !== exp_char.ch || m_last !== exp_char.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("character: expected %h last %0b, got %h last %0b",
                                 exp_char.ch, exp_char.last, m_character, m_last);
                end
            end
        end

        // switch to a new random stall pattern at regular intervals
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);

        if (hold_seen != hold_id) begin
            hold_seen = hold_id;
            hold_left = 300;
        end

        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;                             // no stalls
                1: m_ready <= ($urandom_range(0, 3) != 0);      // light random stalls
                2: m_ready <= (rx_cycle % 5 < 2);               // periodic, mostly stalled
                default: m_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    int burst_left = 0;

    // bursts of back-to-back requests with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            s_value <= $urandom;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // hold one request until it is taken, then record what it should print
    task automatic offer_value(input logic [i2a_pkg::DATA_W-1:0] v, input string typed);
        int i;
        s_value <= v;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed.len() != 0) begin
            for (i = 0; i < typed.len(); i++)
                pending_text.push_back('{ch: typed[i], last: (i == typed.len() - 1)});
        end else begin
            predict_decimal_text(v);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_text.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [i2a_pkg::DATA_W-1:0] pow10 [10];
        logic [i2a_pkg::DATA_W-1:0] v;
        int                         k;
        int                         r;

        pow10[0] = 32'd1;
        for (k = 1; k < 10; k++)
            pow10[k] = pow10[k-1] * 32'd10;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        for (k = 0; k < N_DIR; k++) begin
            pace_sender();
            offer_value(dir_rows[k].value, dir_rows[k].text);
        end

        // sender pause until the pipeline is empty
        wait_drained();

        // random values of every size and sign
        for (r = 0; r < 80; r++) begin
            if (r == 30)
                hold_id <= hold_id + 1;     // long output hold-off, input keeps going
            if (r == 65)
                wait_drained();

            case ($urandom_range(0, 9)) inside
                [0:3]: v = $urandom;
                [4:5]: begin
                    // short numbers, either sign
                    v = $urandom_range(0, 999);
                    if ($urandom_range(0, 1)) v = '0 - v;
                end
                [6:7]: begin
                    // around a power of ten, where the digit count changes
                    v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1)) v = '0 - v;
                end
                8: begin
                    // near the ends of the range
                    v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                             : 32'h7FFF_FFFF - $urandom_range(0, 3);
                end
                default: begin
                    // random digit count
                    v = $urandom % pow10[$urandom_range(1, 9)];
                    if ($urandom_range(0, 1)) v = '0 - v;
                end
            endcase

            pace_sender();
            offer_value(v, "");
        end

        wait_drained();
        // let any stray character show up
        repeat (60) @(posedge aclk);

        if (mismatch_count == 0 && pending_text.size() == 0) begin
            $display("signed_int_to_decimal_ascii_top: match");
        end else begin
            $display("signed_int_to_decimal_ascii_top: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("signed_int_to_decimal_ascii_top: mismatch");
        $finish;
    end

endmodule
